### rtl/dmxs_pkg.sv
// Shared constants and types of the DMX512 frame sender.
package dmxs_pkg;

	localparam int LAST_CHANNEL_DEF = 512;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;

	typedef enum logic [KIND_W-1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_BREAK,
		CMD_START
	} cmd_kind_t;

endpackage

### rtl/dmxs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dmxs_ram #(
	parameter int W = dmxs_pkg::BYTE_W,
	parameter int DEPTH = dmxs_pkg::LAST_CHANNEL_DEF + 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/dmxs_cmd_fifo.sv
// Two-entry command queue between the front and the back of the frame sender.
module dmxs_cmd_fifo #(
	parameter int W = dmxs_pkg::KIND_W + 10 + dmxs_pkg::BYTE_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("command popped from an empty queue");

endmodule

### rtl/dmxs_front.sv
// Front end: accepts requests, tracks the SPI and transmit positions, issues commands.
module dmxs_front #(
	parameter int LAST_CHANNEL = dmxs_pkg::LAST_CHANNEL_DEF,
	localparam int AW = $clog2(LAST_CHANNEL + 1),
	localparam int CMD_W = dmxs_pkg::KIND_W + AW + dmxs_pkg::BYTE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_mode,
	input  logic [dmxs_pkg::BYTE_W-1:0] in_byte,
	input  logic                        in_sync,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	input  logic                        clr_busy,
	input  logic                        fifo_full,
	output logic                        clr_start,
	output logic                        push,
	output logic [CMD_W-1:0]            cmd
);

	localparam logic [AW-1:0] LastA = AW'(LAST_CHANNEL);

	logic [AW-1:0]       spi_pos_q, spi_pos_nxt;
	logic [AW-1:0]       tx_pos_q, tx_pos_nxt;
	logic                brk_q, brk_nxt;
	logic                en_q, en_nxt;
	logic                accept;
	dmxs_pkg::cmd_kind_t kind;
	logic [AW-1:0]       addr;

	// An enable edge starts the buffer clearing pass, so no request may slip in with it.
	assign clr_start = cfg_we && cfg_wdata && !en_q;
	assign in_ready  = !fifo_full && !clr_busy && !clr_start;
	assign accept    = in_valid && in_ready;
	assign cmd       = {kind, addr, in_byte};

	always_comb begin
		spi_pos_nxt = spi_pos_q;
		tx_pos_nxt  = tx_pos_q;
		brk_nxt     = brk_q;
		en_nxt      = en_q;
		push        = 1'b0;
		kind        = dmxs_pkg::CMD_WRITE;
		addr        = spi_pos_q;
		if (accept && !in_mode) begin
			if (in_sync && (in_byte == '0)) begin
				spi_pos_nxt = AW'(1);
			end else begin
				push        = 1'b1;
				spi_pos_nxt = (spi_pos_q == LastA) ? '0 : spi_pos_q + AW'(1);
			end
		end else if (accept && en_q) begin
			push = 1'b1;
			if (brk_q) begin
				kind       = dmxs_pkg::CMD_BREAK;
				brk_nxt    = 1'b0;
				tx_pos_nxt = '0;
			end else if (tx_pos_q == '0) begin
				kind       = dmxs_pkg::CMD_START;
				tx_pos_nxt = AW'(1);
			end else begin
				kind = dmxs_pkg::CMD_READ;
				addr = tx_pos_q;
				if (tx_pos_q == LastA) begin
					brk_nxt = 1'b1;
				end else begin
					tx_pos_nxt = tx_pos_q + AW'(1);
				end
			end
		end
		if (cfg_we) begin
			en_nxt = cfg_wdata;
			if (!cfg_wdata || !en_q) begin
				brk_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spi_pos_q <= '0;
			tx_pos_q  <= '0;
			brk_q     <= 1'b1;
			en_q      <= 1'b0;
		end else begin
			spi_pos_q <= spi_pos_nxt;
			tx_pos_q  <= tx_pos_nxt;
			brk_q     <= brk_nxt;
			en_q      <= en_nxt;
		end
	end

endmodule

### rtl/dmxs_back.sv
// Back end: clears and writes the frame buffer, reads channels and drives the output register.
module dmxs_back #(
	parameter int LAST_CHANNEL = dmxs_pkg::LAST_CHANNEL_DEF,
	localparam int AW = $clog2(LAST_CHANNEL + 1),
	localparam int CMD_W = dmxs_pkg::KIND_W + AW + dmxs_pkg::BYTE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr_start,
	output logic                        clr_busy,
	input  logic                        fifo_empty,
	output logic                        fifo_pop,
	input  logic [CMD_W-1:0]            cmd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dmxs_pkg::BYTE_W-1:0] out_byte,
	output logic                        out_brk,
	output logic                        out_start
);

	localparam int BW = dmxs_pkg::BYTE_W;
	localparam logic [AW-1:0] LastA = AW'(LAST_CHANNEL);

	dmxs_pkg::cmd_kind_t cmd_kind;
	logic [AW-1:0]       cmd_addr;
	logic [BW-1:0]       cmd_data;

	logic                clr_busy_q;
	logic [AW-1:0]       clr_cnt_q;
	logic                valid_s1;
	dmxs_pkg::cmd_kind_t kind_s1;
	logic                out_valid_q;
	logic [BW-1:0]       out_byte_q;
	logic                out_brk_q;
	logic                out_start_q;

	logic                s1_adv;
	logic                is_write;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [BW-1:0]       ram_wdata;
	logic                ram_re;
	logic [BW-1:0]       ram_rdata;

	assign cmd_kind = dmxs_pkg::cmd_kind_t'(cmd[CMD_W-1 -: dmxs_pkg::KIND_W]);
	assign cmd_addr = cmd[BW +: AW];
	assign cmd_data = cmd[BW-1:0];

	assign s1_adv   = !out_valid_q || out_ready;
	assign is_write = (cmd_kind == dmxs_pkg::CMD_WRITE);
	// Writes never wait on the output side; every other request needs a free slot in stage one.
	assign fifo_pop = !fifo_empty && !clr_busy_q && (is_write || !valid_s1 || s1_adv);
	assign ram_re   = fifo_pop && (cmd_kind == dmxs_pkg::CMD_READ);

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = fifo_pop && is_write;
			ram_waddr = cmd_addr;
			ram_wdata = cmd_data;
		end
	end

	dmxs_ram #(
		.W     (BW),
		.DEPTH (LAST_CHANNEL + 1)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cmd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_start) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == LastA) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fifo_pop && !is_write) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop && !is_write) begin
			kind_s1 <= cmd_kind;
		end
		if (s1_adv) begin
			out_byte_q  <= (kind_s1 == dmxs_pkg::CMD_READ) ? ram_rdata : '0;
			out_brk_q   <= (kind_s1 == dmxs_pkg::CMD_BREAK);
			out_start_q <= (kind_s1 == dmxs_pkg::CMD_START);
		end
	end

	assign clr_busy  = clr_busy_q;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_brk   = out_brk_q;
	assign out_start = out_start_q;

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !fifo_pop)
		else $error("command taken during the buffer clearing pass");
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (!valid_s1 || s1_adv))
		else $error("buffer read issued while stage one is stalled");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(kind_s1)))
		else $error("stalled stage one lost its request");

endmodule

### rtl/spi_fed_dmx512_frame_sender.sv
// Top level of the SPI-fed DMX512 frame sender: front end, command queue and back end.
// A transmit request passes the command queue, stage one and the output register on its way
// to m_tvalid; SPI bytes and sync restarts produce no output. Throughput: one request per
// cycle while m_tready is high and no clearing pass runs, set by one frame buffer access per
// command in the back. Reset and each enable edge start a clearing pass over LAST_CHANNEL + 1
// entries (513 by default), one per cycle, with s_tready low; config writes still apply.
module spi_fed_dmx512_frame_sender #(
	parameter int LAST_CHANNEL = dmxs_pkg::LAST_CHANNEL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] spi_byte, [8] sync_pin, [15:9] zero
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] line_byte
	output logic [1:0]  m_tuser,   // [0] is_break, [1] is_start_code
	input  logic        cfg_we,
	input  logic        cfg_wdata  // tx_enable
);

	localparam int AW = $clog2(LAST_CHANNEL + 1);
	localparam int CMD_W = dmxs_pkg::KIND_W + AW + dmxs_pkg::BYTE_W;

	logic             clr_start;
	logic             clr_busy;
	logic             push;
	logic             pop;
	logic             fifo_full;
	logic             fifo_empty;
	logic [CMD_W-1:0] cmd_in;
	logic [CMD_W-1:0] cmd_out;

	dmxs_front #(
		.LAST_CHANNEL (LAST_CHANNEL)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser[0]),
		.in_byte   (s_tdata[7:0]),
		.in_sync   (s_tdata[8]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.clr_busy  (clr_busy),
		.fifo_full (fifo_full),
		.clr_start (clr_start),
		.push      (push),
		.cmd       (cmd_in)
	);

	dmxs_cmd_fifo #(
		.W (CMD_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (fifo_full),
		.pop    (pop),
		.rdata  (cmd_out),
		.empty  (fifo_empty)
	);

	dmxs_back #(
		.LAST_CHANNEL (LAST_CHANNEL)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr_start  (clr_start),
		.clr_busy   (clr_busy),
		.fifo_empty (fifo_empty),
		.fifo_pop   (pop),
		.cmd        (cmd_out),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_brk    (m_tuser[0]),
		.out_start  (m_tuser[1])
	);

endmodule

### bench/spi_fed_dmx512_frame_sender_test.sv
// Self-checking testbench for the SPI-fed DMX512 frame sender.
`timescale 1ns / 100ps

module spi_fed_dmx512_frame_sender_test;

	localparam int LAST_CH = dmxs_pkg::LAST_CHANNEL_DEF;
	localparam int BW = dmxs_pkg::BYTE_W;
	localparam bit MODE_SPI = 1'b0;
	localparam bit MODE_READY = 1'b1;
	localparam bit [9:0] SEND_BREAK_NEXT = 10'd1023;
	localparam int QUIET_CYCLES = 6;
	localparam int MAX_WAIT = 17;

	typedef enum {ENTRY_REQ, ENTRY_CFG, ENTRY_PAUSE} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		bit mode;
		bit [BW-1:0] level;
		bit sync;
		bit enable;
	} plan_entry_t;

	typedef struct packed {
		logic [BW-1:0] line_byte;
		logic brk;
		logic start_code;
	} line_sym_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	plan_entry_t pending[$];
	line_sym_t line_due[$];

	bit [BW-1:0] chan_level [0:LAST_CH];
	bit [9:0] send_pos;
	bit [9:0] fill_pos;
	bit sending_on;

	int quiet_count;
	int send_wait;
	bit send_calm;
	int recv_wait;
	bit recv_calm;
	int fail_count = 0;

	spi_fed_dmx512_frame_sender dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void clear_levels();
		foreach (chan_level[i])
			chan_level[i] = '0;
	endfunction

	function automatic void apply_enable(input bit value);
		if (value && !sending_on) begin
			clear_levels();
			send_pos = SEND_BREAK_NEXT;
		end else if (!value) begin
			send_pos = SEND_BREAK_NEXT;
		end
		sending_on = value;
	endfunction

	function automatic void predict_line_byte(input bit mode, input bit [BW-1:0] level,
			input bit sync);
		line_sym_t sym;
		if (mode == MODE_SPI) begin
			if (sync && level == '0) begin
				fill_pos = 10'd1;
			end else begin
				if (fill_pos <= LAST_CH)
					chan_level[fill_pos] = level;
				fill_pos = fill_pos + 10'd1;
			end
			if (fill_pos > LAST_CH)
				fill_pos = 10'd0;
			return;
		end
		if (!sending_on)
			return;
		if (send_pos == 10'd0) begin
			sym = '{line_byte: '0, brk: 1'b0, start_code: 1'b1};
			send_pos = 10'd1;
		end else if (send_pos <= LAST_CH) begin
			sym = '{line_byte: chan_level[send_pos], brk: 1'b0, start_code: 1'b0};
			send_pos = send_pos + 10'd1;
			if (send_pos > LAST_CH)
				send_pos = SEND_BREAK_NEXT;
		end else begin
			// Any position that is neither the start code nor a channel sends a break.
			sym = '{line_byte: '0, brk: 1'b1, start_code: 1'b0};
			send_pos = 10'd0;
		end
		line_due.push_back(sym);
	endfunction

	always @(posedge clk or negedge arst_n) begin : line_predictor
		if (!arst_n) begin
			clear_levels();
			send_pos = SEND_BREAK_NEXT;
			fill_pos = 10'd0;
			sending_on = 1'b0;
			quiet_count <= 0;
		end else begin
			if (cfg_we)
				apply_enable(cfg_wdata);
			if (s_tvalid && s_tready) begin
				predict_line_byte(s_tuser[0], s_tdata[7:0], s_tdata[8]);
				quiet_count <= 0;
			end else if (quiet_count < QUIET_CYCLES) begin
				quiet_count <= quiet_count + 1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : request_driver
		plan_entry_t head;
		bit valid_next;
		bit we_next;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= 1'b0;
			send_wait <= 0;
			send_calm <= 1'b0;
		end else begin
			valid_next = s_tvalid && !s_tready;
			we_next = 1'b0;
			if (!valid_next) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
				end else if (pending.size() != 0) begin
					head = pending[0];
					if (head.kind == ENTRY_REQ) begin
						void'(pending.pop_front());
						valid_next = 1'b1;
						s_tdata <= {7'd0, head.sync, head.level};
						s_tuser <= head.mode;
						if ($urandom_range(0, 19) == 0)
							send_calm <= !send_calm;
						send_wait <= send_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
					end else if (!s_tvalid && quiet_count >= QUIET_CYCLES &&
							line_due.size() == 0) begin
						// Register writes and pauses go through only once the block is idle.
						void'(pending.pop_front());
						if (head.kind == ENTRY_CFG) begin
							we_next = 1'b1;
							cfg_wdata <= head.enable;
						end
					end
				end
			end
			s_tvalid <= valid_next;
			cfg_we <= we_next;
		end
	end

	always @(posedge clk or negedge arst_n) begin : line_receiver
		int w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait <= 0;
			recv_calm <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			if ($urandom_range(0, 19) == 0)
				recv_calm <= !recv_calm;
			w = recv_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
			recv_wait <= w;
			m_tready <= (w == 0);
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			m_tready <= (recv_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : line_monitor
		line_sym_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (line_due.size() == 0) begin
				$error("line_byte: expected none, got %0h", m_tdata);
				fail_count++;
			end else begin
				want = line_due.pop_front();
				if (m_tdata !== want.line_byte) begin
					$error("line_byte: expected %0h, got %0h", want.line_byte, m_tdata);
					fail_count++;
				end
				if (m_tuser[0] !== want.brk) begin
					$error("is_break: expected %0d, got %0d", want.brk, m_tuser[0]);
					fail_count++;
				end
				if (m_tuser[1] !== want.start_code) begin
					$error("is_start_code: expected %0d, got %0d", want.start_code,
						m_tuser[1]);
					fail_count++;
				end
			end
		end
	end

	task automatic add_req(input bit mode, input bit [BW-1:0] level, input bit sync);
		pending.push_back('{kind: ENTRY_REQ, mode: mode, level: level, sync: sync,
			enable: 1'b0});
	endtask

	task automatic add_cfg(input bit enable);
		pending.push_back('{kind: ENTRY_CFG, mode: 1'b0, level: '0, sync: 1'b0,
			enable: enable});
	endtask

	task automatic add_pause();
		pending.push_back('{kind: ENTRY_PAUSE, mode: 1'b0, level: '0, sync: 1'b0,
			enable: 1'b0});
	endtask

	task automatic add_mixed(input int count, input int restart_pct);
		bit [BW-1:0] b;
		for (int i = 0; i < count; i++) begin
			b = BW'($urandom);
			if ($urandom_range(0, 99) < restart_pct)
				add_req(MODE_SPI, '0, 1'b1);
			else
				add_req(1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		int spi_left;
		int ready_left;
		bit [BW-1:0] b;
		bit s;

		// Directed part: disabled behavior, sync restarts, enable edges and a frame start.
		add_cfg(1'b0);
		add_req(MODE_READY, 8'hFF, 1'b1);
		add_req(MODE_SPI, 8'hFF, 1'b0);
		add_req(MODE_SPI, 8'h00, 1'b1);
		add_req(MODE_SPI, 8'hA5, 1'b0);
		add_req(MODE_SPI, 8'h00, 1'b0);
		add_req(MODE_SPI, 8'h80, 1'b1);
		add_cfg(1'b1);
		add_req(MODE_SPI, 8'h00, 1'b1);
		add_req(MODE_SPI, 8'hFF, 1'b0);
		add_req(MODE_SPI, 8'h01, 1'b1);
		add_req(MODE_SPI, 8'h7F, 1'b0);
		repeat (5) add_req(MODE_READY, 8'h00, 1'b0);
		add_cfg(1'b1);
		add_req(MODE_READY, 8'hAA, 1'b1);
		add_req(MODE_READY, 8'h55, 1'b0);
		add_cfg(1'b0);
		add_req(MODE_READY, 8'h00, 1'b0);
		add_req(MODE_SPI, 8'h55, 1'b1);
		add_cfg(1'b1);
		repeat (3) add_req(MODE_READY, 8'h00, 1'b0);

		// Long enabled stretch: channel writes interleaved with enough transmit requests to
		// run past the end of a frame and into the next break and start code.
		add_req(MODE_SPI, 8'h00, 1'b1);
		spi_left = 100;
		ready_left = 520;
		while (spi_left + ready_left > 0) begin
			if (spi_left > 0 && (ready_left == 0 || $urandom_range(0, 1) == 1)) begin
				b = BW'($urandom);
				s = 1'($urandom_range(0, 1));
				if (spi_left > 80 && $urandom_range(0, 9) == 0) begin
					b = '0;
					s = 1'b1;
				end else if (b == '0) begin
					s = 1'b0;
				end
				add_req(MODE_SPI, b, s);
				spi_left--;
			end else begin
				add_req(MODE_READY, BW'($urandom), 1'($urandom_range(0, 1)));
				ready_left--;
			end
		end

		add_pause();
		add_cfg(1'b0);
		add_mixed(20, 5);
		add_cfg(1'b0);
		add_cfg(1'b1);
		add_mixed(30, 5);
		add_pause();
		add_mixed(30, 5);
		add_cfg(1'b1);
		add_mixed(40, 5);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_tvalid || line_due.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES * 4) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
rtl/dmxs_pkg.sv
rtl/dmxs_ram.sv
rtl/dmxs_cmd_fifo.sv
rtl/dmxs_front.sv
rtl/dmxs_back.sv
rtl/spi_fed_dmx512_frame_sender.sv
bench/spi_fed_dmx512_frame_sender_test.sv
